[hw/rtl/slt_pkg.sv]
// Shared types, widths and codes of the supercover line obstacle tracer.
package slt_pkg;

    localparam int COORD_W = 12;
    localparam int LIM_W = COORD_W + 1;
    localparam int CFG_W = 10;
    localparam int PIX_W = 9;
    localparam int LEN_W = 12;
    localparam int ERR_W = 13;
    localparam int CFG_IDX_W = 2;
    localparam int DEF_MAX_WIDTH = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] MAP_WIDTH_RESET = 10'd512;
    localparam logic [CFG_W-1:0] MAP_HEIGHT_RESET = 10'd512;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_TRACE = 1'b1;

    typedef struct packed {
        logic                      req_type;
        logic signed [COORD_W-1:0] start_col;
        logic signed [COORD_W-1:0] start_row;
        logic signed [COORD_W-1:0] end_col;
        logic signed [COORD_W-1:0] end_row;
        logic [PIX_W-1:0]          pixel_col;
        logic [PIX_W-1:0]          pixel_row;
        logic                      pixel_value;
    } req_t;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] hit_col;
        logic signed [COORD_W-1:0] hit_row;
    } rsp_t;

    typedef struct packed {
        logic                      is_trace;
        logic signed [COORD_W-1:0] start_col;
        logic signed [COORD_W-1:0] start_row;
        logic [LEN_W-1:0]          dmaj;
        logic [LEN_W-1:0]          dmin;
        logic                      col_neg;
        logic                      row_neg;
        logic                      row_major;
        logic [PIX_W-1:0]          pixel_col;
        logic [PIX_W-1:0]          pixel_row;
        logic                      pixel_value;
    } cmd_t;

    typedef struct packed {
        logic [CFG_W-1:0] map_width;
        logic [CFG_W-1:0] map_height;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_TEST,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

[hw/rtl/slt_front.sv]
// Front stage: accepts request beats and classifies traces into line commands.
module slt_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  slt_pkg::req_t req,
    input  logic          q_full,
    output logic          push_valid,
    output slt_pkg::cmd_t push_cmd
);
    import slt_pkg::*;

    logic                  front_valid_reg;
    logic                  front_valid_next;
    cmd_t                  cmd_reg;
    cmd_t                  cmd_next;
    logic                  accept;
    logic signed [COORD_W:0] dc;
    logic signed [COORD_W:0] dr;
    logic [COORD_W:0]      adc;
    logic [COORD_W:0]      adr;
    logic [LEN_W-1:0]      len_c;
    logic [LEN_W-1:0]      len_r;

    assign req_stall = front_valid_reg && q_full;
    assign accept = req_valid && !req_stall;
    assign push_valid = front_valid_reg && !q_full;
    assign push_cmd = cmd_reg;

    always_comb
    begin
        dc = {req.end_col[COORD_W-1], req.end_col} - {req.start_col[COORD_W-1], req.start_col};
        dr = {req.end_row[COORD_W-1], req.end_row} - {req.start_row[COORD_W-1], req.start_row};
        adc = dc[COORD_W] ? -dc : dc;
        adr = dr[COORD_W] ? -dr : dr;
        len_c = adc[LEN_W-1:0];
        len_r = adr[LEN_W-1:0];

        cmd_next.is_trace = (req.req_type == REQ_TRACE);
        cmd_next.start_col = req.start_col;
        cmd_next.start_row = req.start_row;
        cmd_next.col_neg = dc[COORD_W];
        cmd_next.row_neg = dr[COORD_W];
        cmd_next.row_major = (len_r >= len_c);
        cmd_next.dmaj = (len_r >= len_c) ? len_r : len_c;
        cmd_next.dmin = (len_r >= len_c) ? len_c : len_r;
        cmd_next.pixel_col = req.pixel_col;
        cmd_next.pixel_row = req.pixel_row;
        cmd_next.pixel_value = req.pixel_value;
    end

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (accept)
        begin
            front_valid_next = 1'b1;
        end
        else if (push_valid)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

[hw/rtl/slt_queue.sv]
// Short command queue between the front stage and the line walker.
module slt_queue #(
    parameter int DEPTH = slt_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  slt_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output slt_pkg::cmd_t head
);
    import slt_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    cmd_t            slots_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign full = (count_reg == FullCnt);
    assign empty = (count_reg == '0);
    assign head = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[hw/rtl/slt_back.sv]
// Back stage: occupancy bitmap, supercover line walker and result register.
module slt_back #(
    parameter int MAX_WIDTH = slt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = slt_pkg::DEF_MAX_HEIGHT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  slt_pkg::cfg_t cfg,
    input  logic          q_empty,
    input  slt_pkg::cmd_t q_head,
    output logic          q_pop,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output slt_pkg::rsp_t rsp
);
    import slt_pkg::*;

    localparam int ColIdxW = $clog2(MAX_WIDTH);
    localparam int RowIdxW = $clog2(MAX_HEIGHT);
    localparam logic [LIM_W-1:0] MaxW = LIM_W'(MAX_WIDTH);
    localparam logic [LIM_W-1:0] MaxH = LIM_W'(MAX_HEIGHT);
    localparam logic signed [COORD_W-1:0] OneC = 1;
    localparam int T_START = 0;
    localparam int T_SIDE_A = 1;
    localparam int T_SIDE_B = 2;
    localparam int T_MAIN = 3;

    logic occ_mem [MAX_HEIGHT][MAX_WIDTH];

    state_t                    state_reg;
    state_t                    state_next;
    cmd_t                      cmd_reg;
    cmd_t                      cmd_next;
    logic signed [COORD_W-1:0] c_reg;
    logic signed [COORD_W-1:0] c_next;
    logic signed [COORD_W-1:0] r_reg;
    logic signed [COORD_W-1:0] r_next;
    logic signed [COORD_W-1:0] oc_reg;
    logic signed [COORD_W-1:0] oc_next;
    logic signed [COORD_W-1:0] or_reg;
    logic signed [COORD_W-1:0] or_next;
    logic [ERR_W-1:0]          err_reg;
    logic [ERR_W-1:0]          err_next;
    logic [ERR_W-1:0]          prev_reg;
    logic [ERR_W-1:0]          prev_next;
    logic [LEN_W-1:0]          cnt_reg;
    logic [LEN_W-1:0]          cnt_next;
    logic [3:0]                mask_reg;
    logic [3:0]                mask_next;
    logic                      first_reg;
    logic                      first_next;
    logic                      pend_valid_reg;
    logic                      pend_valid_next;
    logic                      pend_oob_reg;
    logic                      pend_oob_next;
    logic                      hit_acc_reg;
    logic                      hit_acc_next;
    logic                      res_hit_reg;
    logic                      res_hit_next;
    logic signed [COORD_W-1:0] res_col_reg;
    logic signed [COORD_W-1:0] res_col_next;
    logic signed [COORD_W-1:0] res_row_reg;
    logic signed [COORD_W-1:0] res_row_next;
    rsp_t                      rsp_reg;
    rsp_t                      rsp_next;
    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    logic                      mem_q_reg;

    logic [LIM_W-1:0]          w_lim;
    logic [LIM_W-1:0]          h_lim;
    logic [3:0]                sel;
    logic signed [COORD_W-1:0] pt_col;
    logic signed [COORD_W-1:0] pt_row;
    logic                      pt_oob;
    logic                      rd_en;
    logic                      wr_en;
    logic                      pend_blocked;
    logic                      hit_now;
    logic                      finish;
    logic                      rsp_free;

    logic [ERR_W-1:0]          dd_maj;
    logic [ERR_W-1:0]          dd_min;
    logic [ERR_W:0]            e1;
    logic [ERR_W:0]            e2;
    logic [ERR_W:0]            sum;
    logic                      minor_step;
    logic                      sum_gt;
    logic                      sum_lt;
    logic                      side_lo;
    logic                      side_hi;
    logic                      step_col;
    logic                      step_row;
    logic signed [COORD_W-1:0] c_adv;
    logic signed [COORD_W-1:0] r_adv;
    logic [ERR_W-1:0]          err_adv;
    logic [3:0]                mask_adv;

    assign w_lim = ({{(LIM_W - CFG_W){1'b0}}, cfg.map_width} < MaxW)
                 ? {{(LIM_W - CFG_W){1'b0}}, cfg.map_width} : MaxW;
    assign h_lim = ({{(LIM_W - CFG_W){1'b0}}, cfg.map_height} < MaxH)
                 ? {{(LIM_W - CFG_W){1'b0}}, cfg.map_height} : MaxH;

    assign pend_blocked = pend_valid_reg && (pend_oob_reg || mem_q_reg);
    assign hit_now = hit_acc_reg || pend_blocked;
    assign finish = hit_now || (cnt_reg == cmd_reg.dmaj);
    assign rsp_free = !rsp_valid_reg || !rsp_stall;
    assign q_pop = (state_reg == ST_IDLE) && !q_empty;
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

    // One Bresenham step along the major axis, with the side squares it must test.
    always_comb
    begin
        dd_maj = {cmd_reg.dmaj, 1'b0};
        dd_min = {cmd_reg.dmin, 1'b0};
        e1 = {1'b0, err_reg} + {1'b0, dd_min};
        minor_step = (e1 > {1'b0, dd_maj});
        e2 = minor_step ? (e1 - {1'b0, dd_maj}) : e1;
        err_adv = e2[ERR_W-1:0];
        sum = {1'b0, err_adv} + {1'b0, prev_reg};
        sum_gt = (sum > {1'b0, dd_maj});
        sum_lt = (sum < {1'b0, dd_maj});
        side_lo = minor_step && !sum_gt;
        side_hi = minor_step && !sum_lt;
        step_col = cmd_reg.row_major ? minor_step : 1'b1;
        step_row = cmd_reg.row_major ? 1'b1 : minor_step;
        c_adv = step_col ? (cmd_reg.col_neg ? c_reg - OneC : c_reg + OneC) : c_reg;
        r_adv = step_row ? (cmd_reg.row_neg ? r_reg - OneC : r_reg + OneC) : r_reg;
        mask_adv[T_START] = first_reg;
        mask_adv[T_SIDE_A] = cmd_reg.row_major ? side_lo : side_hi;
        mask_adv[T_SIDE_B] = cmd_reg.row_major ? side_hi : side_lo;
        mask_adv[T_MAIN] = 1'b1;
    end

    always_comb
    begin
        sel = '0;
        pt_col = c_reg;
        pt_row = r_reg;
        if (mask_reg[T_START])
        begin
            sel[T_START] = 1'b1;
            pt_col = oc_reg;
            pt_row = or_reg;
        end
        else if (mask_reg[T_SIDE_A])
        begin
            sel[T_SIDE_A] = 1'b1;
            pt_col = oc_reg;
            pt_row = r_reg;
        end
        else if (mask_reg[T_SIDE_B])
        begin
            sel[T_SIDE_B] = 1'b1;
            pt_col = c_reg;
            pt_row = or_reg;
        end
        else
        begin
            sel[T_MAIN] = 1'b1;
        end
        pt_oob = pt_col[COORD_W-1] || pt_row[COORD_W-1]
              || ({1'b0, pt_col} >= w_lim) || ({1'b0, pt_row} >= h_lim);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty && q_head.is_trace)
                begin
                    state_next = (q_head.dmaj == '0) ? ST_DONE : ST_STEP;
                end
            end
            ST_STEP:
            begin
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if ((mask_reg & ~sel) == '0)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = finish ? ST_DONE : ST_TEST;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_next = cmd_reg;
        c_next = c_reg;
        r_next = r_reg;
        oc_next = oc_reg;
        or_next = or_reg;
        err_next = err_reg;
        prev_next = prev_reg;
        cnt_next = cnt_reg;
        mask_next = mask_reg;
        first_next = first_reg;
        pend_valid_next = pend_valid_reg;
        pend_oob_next = pend_oob_reg;
        hit_acc_next = hit_acc_reg;
        res_hit_next = res_hit_reg;
        res_col_next = res_col_reg;
        res_row_next = res_row_reg;
        rsp_next = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rd_en = 1'b0;
        wr_en = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_head.is_trace)
                    begin
                        cmd_next = q_head;
                        c_next = q_head.start_col;
                        r_next = q_head.start_row;
                        err_next = {1'b0, q_head.dmaj};
                        prev_next = {1'b0, q_head.dmaj};
                        cnt_next = '0;
                        first_next = 1'b1;
                        hit_acc_next = 1'b0;
                        pend_valid_next = 1'b0;
                        res_hit_next = 1'b0;
                        res_col_next = '0;
                        res_row_next = '0;
                    end
                    else
                    begin
                        wr_en = (int'(q_head.pixel_col) < MAX_WIDTH)
                             && (int'(q_head.pixel_row) < MAX_HEIGHT);
                    end
                end
            end
            ST_STEP:
            begin
                oc_next = c_reg;
                or_next = r_reg;
                c_next = c_adv;
                r_next = r_adv;
                err_next = err_adv;
                prev_next = err_adv;
                cnt_next = cnt_reg + 1'b1;
                mask_next = mask_adv;
                first_next = 1'b0;
            end
            ST_TEST:
            begin
                mask_next = mask_reg & ~sel;
                pend_valid_next = 1'b1;
                pend_oob_next = pt_oob;
                hit_acc_next = hit_acc_reg || pend_blocked;
                rd_en = !pt_oob;
            end
            ST_DRAIN:
            begin
                pend_valid_next = 1'b0;
                if (finish)
                begin
                    res_hit_next = hit_now;
                    res_col_next = hit_now ? c_reg : '0;
                    res_row_next = hit_now ? r_reg : '0;
                end
                else
                begin
                    hit_acc_next = 1'b0;
                    oc_next = c_reg;
                    or_next = r_reg;
                    c_next = c_adv;
                    r_next = r_adv;
                    err_next = err_adv;
                    prev_next = err_adv;
                    cnt_next = cnt_reg + 1'b1;
                    mask_next = mask_adv;
                    first_next = 1'b0;
                end
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_next.hit = res_hit_reg;
                    rsp_next.hit_col = res_col_reg;
                    rsp_next.hit_row = res_row_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            mask_reg <= '0;
            first_reg <= 1'b0;
            hit_acc_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            mask_reg <= mask_next;
            first_reg <= first_next;
            hit_acc_reg <= hit_acc_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        c_reg <= c_next;
        r_reg <= r_next;
        oc_reg <= oc_next;
        or_reg <= or_next;
        err_reg <= err_next;
        prev_reg <= prev_next;
        pend_oob_reg <= pend_oob_next;
        res_hit_reg <= res_hit_next;
        res_col_reg <= res_col_next;
        res_row_reg <= res_row_next;
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            occ_mem[RowIdxW'(q_head.pixel_row)][ColIdxW'(q_head.pixel_col)]
                <= q_head.pixel_value;
        end
        if (rd_en)
        begin
            mem_q_reg <= occ_mem[pt_row[RowIdxW-1:0]][pt_col[ColIdxW-1:0]];
        end
    end

    a_test_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TEST) |-> (mask_reg != '0))
        else $error("test phase entered with no square left to test");

    a_drain_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> pend_valid_reg)
        else $error("drain phase without a pending bitmap read");

    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TEST) |-> ((cnt_reg != '0) && (cnt_reg <= cmd_reg.dmaj)))
        else $error("step count outside the line length");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && !res_hit_reg) |-> ((res_col_reg == '0) && (res_row_reg == '0)))
        else $error("miss result carries nonzero coordinates");

    a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && rsp_free) |=> (rsp_valid_reg && (state_reg == ST_IDLE)))
        else $error("finished trace did not reach the result register");

endmodule

[hw/rtl/supercover_line_obstacle_trace_unit.sv]
// Top level of the supercover line obstacle tracer: configuration registers and stage wiring.
//
// Requests arrive on the req channel (req_valid, req_stall); a beat is taken when
// req_valid is high and req_stall is low. A write request stores one bitmap pixel
// and yields no result. A trace request yields exactly one beat on the rsp channel
// (rsp_valid, rsp_stall): hit and the first blocked step position, or zeros.
// The front stage registers and classifies each beat and hands it to a four-entry
// queue, so requests keep flowing while the line walker is busy.
// A write is stored in the bitmap while the walker is idle. A trace of n major-axis
// steps tests, at each step, the main square, the one or two side squares of a
// diagonal step and, on the first step, the start square, then drains the last read,
// and stops at the first blocked step. The single bitmap read port sets the pace, one
// square per cycle. A zero-length trace tests no squares and answers with zeros.
// map_width and map_height are written on the cfg channel by the user only while the
// block is idle; the block does not enforce it. cfg_ready is always high. Reset clears
// the control state, empties the queue and restores both sizes to 512; bitmap contents
// are undefined until written. While rsp_stall holds, the result stays in the output
// register, the walker waits with the next result, and the queue fills until req_stall
// rises.
module supercover_line_obstacle_trace_unit #(
    parameter int MAX_WIDTH = slt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = slt_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  slt_pkg::req_t                    req,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output slt_pkg::rsp_t                    rsp,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [slt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [slt_pkg::CFG_W-1:0]        cfg_data
);
    import slt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic push_valid;
    cmd_t push_cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;
    cmd_t q_head;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAP_WIDTH:  cfg_next.map_width = cfg_data;
                REG_MAP_HEIGHT: cfg_next.map_height = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.map_width <= MAP_WIDTH_RESET;
            cfg_reg.map_height <= MAP_HEIGHT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    slt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    slt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push_valid),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    slt_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

[test/slt_trace_checker.sv]
// Checker for the line tracer: predicts each trace result from the observed beats and compares.
module slt_trace_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  slt_pkg::req_t                 req,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  slt_pkg::rsp_t                 rsp,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [slt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [slt_pkg::CFG_W-1:0]     cfg_data,
    output int                            mismatch_count,
    output int                            results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import slt_pkg::*;

    localparam int MAP_COLS = DEF_MAX_WIDTH;
    localparam int MAP_ROWS = DEF_MAX_HEIGHT;

    bit               bitmap [MAP_COLS * MAP_ROWS];
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    rsp_t             expected_hits [$];

    task automatic report_mismatch(input string field, input logic signed [31:0] got,
                                   input logic signed [31:0] want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, field, got, want);
        mismatch_count++;
    endtask

    function automatic bit square_blocked(input int col, input int row);
        int lim_c;
        int lim_r;
        lim_c = (width_reg > MAP_COLS) ? MAP_COLS : int'(width_reg);
        lim_r = (height_reg > MAP_ROWS) ? MAP_ROWS : int'(height_reg);
        if (col < 0 || row < 0 || col >= lim_c || row >= lim_r)
            return 1'b1;
        return bitmap[row * MAP_COLS + col];
    endfunction

    function automatic rsp_t trace_result(input req_t q);
        rsp_t res;
        int   c, r, dc, dr, cs, rs, err, prev_err, n;
        bit   blk;
        c = $signed(q.start_col);
        r = $signed(q.start_row);
        dc = $signed(q.end_col) - c;
        dr = $signed(q.end_row) - r;
        blk = square_blocked(c, r);
        cs = 1;
        rs = 1;
        if (dc < 0)
        begin
            cs = -1;
            dc = -dc;
        end
        if (dr < 0)
        begin
            rs = -1;
            dr = -dr;
        end
        if (2 * dr >= 2 * dc)
        begin
            err = dr;
            prev_err = dr;
            for (n = 0; n < dr; n++)
            begin
                r += rs;
                err += 2 * dc;
                if (err > 2 * dr)
                begin
                    c += cs;
                    err -= 2 * dr;
                    if (err + prev_err < 2 * dr)
                        blk = blk || square_blocked(c - cs, r);
                    else if (err + prev_err > 2 * dr)
                        blk = blk || square_blocked(c, r - rs);
                    else
                        blk = blk || square_blocked(c - cs, r) || square_blocked(c, r - rs);
                end
                blk = blk || square_blocked(c, r);
                prev_err = err;
                if (blk)
                    break;
            end
        end
        else
        begin
            err = dc;
            prev_err = dc;
            for (n = 0; n < dc; n++)
            begin
                c += cs;
                err += 2 * dr;
                if (err > 2 * dc)
                begin
                    r += rs;
                    err -= 2 * dc;
                    if (err + prev_err < 2 * dc)
                        blk = blk || square_blocked(c, r - rs);
                    else if (err + prev_err > 2 * dc)
                        blk = blk || square_blocked(c - cs, r);
                    else
                        blk = blk || square_blocked(c, r - rs) || square_blocked(c - cs, r);
                end
                blk = blk || square_blocked(c, r);
                prev_err = err;
                if (blk)
                    break;
            end
        end
        res = '0;
        if (blk && (dr != 0 || dc != 0))
        begin
            res.hit = 1'b1;
            res.hit_col = COORD_W'(c);
            res.hit_row = COORD_W'(r);
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            width_reg = MAP_WIDTH_RESET;
            height_reg = MAP_HEIGHT_RESET;
            expected_hits.delete();
            mismatch_count = 0;
            results_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MAP_WIDTH)
                    width_reg = cfg_data;
                else if (cfg_index == REG_MAP_HEIGHT)
                    height_reg = cfg_data;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_hits.size() == 0)
                    report_mismatch("unexpected result beat, hit", 32'(rsp.hit), 0);
                else
                begin
                    want = expected_hits.pop_front();
                    if (rsp.hit !== want.hit)
                        report_mismatch("hit", 32'(rsp.hit), 32'(want.hit));
                    if (rsp.hit_col !== want.hit_col)
                        report_mismatch("hit_col", 32'(rsp.hit_col), 32'(want.hit_col));
                    if (rsp.hit_row !== want.hit_row)
                        report_mismatch("hit_row", 32'(rsp.hit_row), 32'(want.hit_row));
                end
            end
            if (req_valid && !req_stall)
            begin
                if (req.req_type == REQ_WRITE)
                begin
                    if (req.pixel_col < MAP_COLS && req.pixel_row < MAP_ROWS)
                        bitmap[req.pixel_row * MAP_COLS + req.pixel_col] = req.pixel_value;
                end
                else
                    expected_hits.push_back(trace_result(req));
            end
            results_pending <= expected_hits.size();
        end
    end

endmodule

[test/testbench.sv]
// Top of the line tracer testbench: clock, reset, stimulus, back-pressure and the verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import slt_pkg::*;

    localparam int MAP_COLS = DEF_MAX_WIDTH;
    localparam int MAP_ROWS = DEF_MAX_HEIGHT;
    localparam int IDLE_LIMIT = 100000;
    localparam int SETTLE_CYCLES = 64;
    localparam int OPS_PER_PHASE = 15;
    localparam int NUM_PHASES = 8;
    localparam int SHORT_REACH = 5;
    localparam int LONG_REACH = 44;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    req_t                 req;
    logic                 rsp_valid;
    logic                 rsp_stall;
    rsp_t                 rsp;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   mismatch_count;
    int                   results_pending;
    int                   idle_cycles;

    bit                   quiet;
    bit                   loaded [MAP_COLS * MAP_ROWS];
    logic [CFG_W-1:0]     cur_w;
    logic [CFG_W-1:0]     cur_h;

    logic [CFG_W-1:0] phase_w [NUM_PHASES] = '{10'd16, 10'd1, 10'd0, 10'd512,
                                               10'd1023, 10'd5, 10'd40, 10'd512};
    logic [CFG_W-1:0] phase_h [NUM_PHASES] = '{10'd16, 10'd1, 10'd9, 10'd512,
                                               10'd5, 10'd1023, 10'd23, 10'd0};

    supercover_line_obstacle_trace_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    slt_trace_checker trace_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req             (req),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .rsp             (rsp),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int draw_gap();
        return quiet ? 0 : int'($urandom_range(0, 12));
    endfunction

    function automatic int span_cols();
        return (cur_w > MAP_COLS) ? MAP_COLS : int'(cur_w);
    endfunction

    function automatic int span_rows();
        return (cur_h > MAP_ROWS) ? MAP_ROWS : int'(cur_h);
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    function automatic req_t random_item();
        req_t item;
        item.req_type = 1'($urandom_range(0, 1));
        item.start_col = COORD_W'($urandom_range(0, 4095));
        item.start_row = COORD_W'($urandom_range(0, 4095));
        item.end_col = COORD_W'($urandom_range(0, 4095));
        item.end_row = COORD_W'($urandom_range(0, 4095));
        item.pixel_col = PIX_W'($urandom_range(0, 511));
        item.pixel_row = PIX_W'($urandom_range(0, 511));
        item.pixel_value = 1'($urandom_range(0, 1));
        return item;
    endfunction

    task automatic send_req(input req_t item);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do @(posedge clk); while (req_stall);
    endtask

    task automatic put_pixel(input int col, input int row, input bit val);
        req_t item;
        item = random_item();
        item.req_type = REQ_WRITE;
        item.pixel_col = PIX_W'(col);
        item.pixel_row = PIX_W'(row);
        item.pixel_value = val;
        send_req(item);
        loaded[row * MAP_COLS + col] = 1'b1;
    endtask

    task automatic fill_square(input int col, input int row, inout bit off_map);
        if (col < 0 || row < 0 || col >= span_cols() || row >= span_rows())
            off_map = 1'b1;
        else if (!loaded[row * MAP_COLS + col])
            put_pixel(col, row, $urandom_range(0, 9) == 0);
    endtask

    // Every square the walk may read is loaded before the trace beat goes out.
    task automatic send_trace(input int sc, input int sr, input int ec, input int er);
        req_t item;
        int   c, r, dc, dr, cs, rs, err, n, steps;
        bit   row_major;
        bit   off_map;
        item = random_item();
        item.req_type = REQ_TRACE;
        item.start_col = COORD_W'(sc);
        item.start_row = COORD_W'(sr);
        item.end_col = COORD_W'(ec);
        item.end_row = COORD_W'(er);
        c = sc;
        r = sr;
        dc = (ec >= sc) ? ec - sc : sc - ec;
        dr = (er >= sr) ? er - sr : sr - er;
        cs = (ec >= sc) ? 1 : -1;
        rs = (er >= sr) ? 1 : -1;
        row_major = (dr >= dc);
        steps = row_major ? dr : dc;
        err = steps;
        off_map = 1'b0;
        fill_square(c, r, off_map);
        for (n = 0; n < steps; n++)
        begin
            if (row_major)
            begin
                r += rs;
                err += 2 * dc;
                if (err > 2 * dr)
                begin
                    c += cs;
                    err -= 2 * dr;
                    fill_square(c - cs, r, off_map);
                    fill_square(c, r - rs, off_map);
                end
            end
            else
            begin
                c += cs;
                err += 2 * dr;
                if (err > 2 * dc)
                begin
                    r += rs;
                    err -= 2 * dc;
                    fill_square(c, r - rs, off_map);
                    fill_square(c - cs, r, off_map);
                end
            end
            fill_square(c, r, off_map);
            if (off_map)
                break;
        end
        send_req(item);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_MAP_WIDTH)
            cur_w = val;
        else if (idx == REG_MAP_HEIGHT)
            cur_h = val;
    endtask

    task automatic settle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (results_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int hold;
        rsp_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = draw_gap();
            if (hold > 0)
            begin
                @(negedge clk);
                rsp_stall <= 1'b1;
                repeat (hold - 1) @(negedge clk);
                @(negedge clk);
                rsp_stall <= 1'b0;
            end
            do @(posedge clk); while (!rsp_valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int ph, op, kind, cols, rows, reach, sc, sr;
        req_valid = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MAP_WIDTH;
        cfg_data = '0;
        rst_n = 1'b0;
        quiet = 1'b0;
        cur_w = MAP_WIDTH_RESET;
        cur_h = MAP_HEIGHT_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed beats under the reset sizes.
        put_pixel(511, 511, 1'b1);
        put_pixel(0, 0, 1'b0);
        send_trace(3, 3, 3, 3);
        send_trace(-5, -5, -5, -5);
        send_trace(-1, 2, 4, 2);
        send_trace(-2048, -2048, 2047, 2047);
        send_trace(2047, -2048, -2048, 2047);
        send_trace(0, 10, 9, 10);
        send_trace(9, 12, 0, 12);
        send_trace(20, 0, 20, 9);
        send_trace(21, 9, 21, 0);
        put_pixel(11, 10, 1'b1);
        send_trace(10, 10, 12, 12);
        send_trace(30, 30, 37, 33);
        send_trace(40, 30, 43, 37);
        send_trace(50, 37, 43, 30);
        send_trace(505, 100, 515, 104);
        send_trace(100, 505, 103, 520);
        send_trace(500, 500, 511, 511);

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            if (ph == 0)
            begin
                write_reg(REG_SPARE_A, CFG_W'($urandom_range(0, 1023)));
                write_reg(REG_SPARE_B, CFG_W'($urandom_range(0, 1023)));
            end
            write_reg(REG_MAP_WIDTH, phase_w[ph]);
            write_reg(REG_MAP_HEIGHT, phase_h[ph]);
            for (op = 0; op < OPS_PER_PHASE; op++)
            begin
                if (op % 15 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                kind = $urandom_range(0, 9);
                cols = span_cols();
                rows = span_rows();
                if (kind < 2)
                begin
                    if ($urandom_range(0, 3) == 0 || cols == 0 || rows == 0)
                        put_pixel($urandom_range(0, 511), $urandom_range(0, 511),
                                  $urandom_range(0, 1));
                    else
                        put_pixel($urandom_range(0, cols - 1), $urandom_range(0, rows - 1),
                                  $urandom_range(0, 2) == 0);
                end
                else if (kind == 2)
                    send_trace(rand_coord(), rand_coord(), rand_coord(), rand_coord());
                else
                begin
                    reach = SHORT_REACH;
                    if ($urandom_range(0, 11) == 0)
                        reach = ((cols > rows) ? cols : rows) + 4;
                    if (reach > LONG_REACH)
                        reach = LONG_REACH;
                    sc = int'($urandom_range(0, cols + 3)) - 2;
                    sr = int'($urandom_range(0, rows + 3)) - 2;
                    send_trace(sc, sr, sc + int'($urandom_range(0, 2 * reach)) - reach,
                               sr + int'($urandom_range(0, 2 * reach)) - reach);
                end
            end
        end

        quiet = 1'b0;
        settle();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
